>>> sv/lph_pkg.sv
// lph_pkg: shared widths, command codes, register index and slot row types
// for the linear probing hash lookup block
// no dependencies
package lph_pkg;

   // slot store depth and field widths
   localparam int TABLE_DEPTH = 1024;
   localparam int SLOT_W      = 10;
   localparam int SIZE_W      = 11;
   localparam int KEY_W       = 64;
   localparam int VALUE_W     = 32;

   // start slot reduction, digits of the key taken per cycle
   localparam int MOD_STEP    = 4;
   localparam int MOD_CYCLES  = KEY_W / MOD_STEP;
   localparam int MOD_CNT_W   = $clog2(MOD_CYCLES);

   // csr port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic REG_TABLE_SIZE = 1'b0;   // register index, paddr[2]

   // command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // one slot: used flag (key or sentinel nonzero), key and value
   typedef struct packed {
      logic                 used;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
   } row_type;

   typedef struct packed {
      logic                 en;
      logic [SLOT_W-1:0]    addr;
      row_type              data;
   } ram_wr_type;

endpackage

>>> sv/lph_req_if.sv
// lph_req_if: request channel, valid/ready with load or lookup payload
// depends on lph_pkg
interface lph_req_if;
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [lph_pkg::SLOT_W-1:0]   slot_index;
   logic [lph_pkg::KEY_W-1:0]    entry_key;
   logic [lph_pkg::KEY_W-1:0]    entry_sentinel;
   logic [lph_pkg::VALUE_W-1:0]  entry_value;

   modport source (output valid, cmd, slot_index, entry_key, entry_sentinel, entry_value,
                   input ready);
   modport sink   (input valid, cmd, slot_index, entry_key, entry_sentinel, entry_value,
                   output ready);
endinterface

>>> sv/lph_rsp_if.sv
// lph_rsp_if: response channel, valid/ready with lookup result payload
// depends on lph_pkg
interface lph_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [lph_pkg::VALUE_W-1:0]  result_value;
   logic [lph_pkg::SLOT_W-1:0]   hit_slot;

   modport source (output valid, found, result_value, hit_slot, input ready);
   modport sink   (input valid, found, result_value, hit_slot, output ready);
endinterface

>>> sv/lph_slot_ram.sv
// lph_slot_ram: slot store, one write port and one registered read port
// depends on lph_pkg
module lph_slot_ram (
   input  logic                        clock,
   input  lph_pkg::ram_wr_type         wr,
   input  logic [lph_pkg::SLOT_W-1:0]  rd_addr,
   output lph_pkg::row_type            rd_data
);

   lph_pkg::row_type mem [lph_pkg::TABLE_DEPTH];
   lph_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lph_mod_unit.sv
// lph_mod_unit: key modulo table size, restoring reduction a few key bits a cycle
// depends on lph_pkg
module lph_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lph_pkg::KEY_W-1:0]   dividend,
   input  logic [lph_pkg::SIZE_W-1:0]  divisor,
   output logic                        done,
   output logic [lph_pkg::SLOT_W-1:0]  remainder
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [lph_pkg::MOD_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [lph_pkg::KEY_W-1:0]      quo_ff, quo_in;
   logic [lph_pkg::SIZE_W-1:0]     div_ff, div_in;
   logic [lph_pkg::SLOT_W-1:0]     rem_ff, rem_in;
   logic [lph_pkg::SLOT_W-1:0]     rem_step;
   logic [lph_pkg::SIZE_W-1:0]     trial;

   // remainder stays below divisor (at most 1024), so it fits the slot width
   always_comb begin
      rem_step = rem_ff;
      trial    = '0;
      for (int i = 0; i < lph_pkg::MOD_STEP; i++) begin
         trial = {rem_step, quo_ff[lph_pkg::KEY_W-1-i]};
         if (trial >= div_ff) begin
            trial = trial - div_ff;
         end
         rem_step = trial[lph_pkg::SLOT_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_step;
         quo_in = quo_ff << lph_pkg::MOD_STEP;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lph_pkg::MOD_CNT_W'(lph_pkg::MOD_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, rem_ff} < div_ff))
      else $error("remainder not below divisor");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (div_ff != '0))
      else $error("reduction running with zero divisor");

endmodule

>>> sv/linear_probe_hash_lookup_top.sv
// linear_probe_hash_lookup_top: open addressing hash table with linear probing
// depends on lph_pkg, lph_req_if, lph_rsp_if, lph_slot_ram, lph_mod_unit
//
//   channel  dir  handshake              word
//   req      in   valid/ready            cmd, slot_index, entry_key, entry_sentinel, entry_value
//   rsp      out  valid/ready            found, result_value, hit_slot
//   csr      in   apb, pready always 1   table_size at byte address 0
//
// a load is written to its slot at the edge that accepts it
// a lookup in a nonempty table reduces the key modulo table size (16 steps of 4 key bits),
// then the probe walk reads one slot a cycle from the single read port
// after reset a clearing pass empties all 1024 slots, no word is accepted then
// a finished result waits in the output register; the next word is accepted meanwhile,
// and a later lookup holds its result until the output register frees
module linear_probe_hash_lookup_top (
   input  logic                            clock,
   input  logic                            reset,
   lph_req_if.sink                         req,
   lph_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lph_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lph_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lph_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_MOD   = 5'b00100,
      ST_PROBE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;

   // config
   logic [lph_pkg::SIZE_W-1:0]    table_size_ff, table_size_in;
   logic [lph_pkg::SIZE_W-1:0]    cap_w;
   logic                          csr_wr;

   // clearing pass
   logic [lph_pkg::SLOT_W-1:0]    clr_ff, clr_in;

   // lookup context
   logic [lph_pkg::SIZE_W-1:0]    cap_ff, cap_in;
   logic [lph_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [lph_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [lph_pkg::SIZE_W-1:0]    left_ff, left_in;
   logic [lph_pkg::SIZE_W-1:0]    slot_inc;
   logic [lph_pkg::SLOT_W-1:0]    slot_next;

   // pending result
   logic                          res_found_ff, res_found_in;
   logic [lph_pkg::VALUE_W-1:0]   res_value_ff, res_value_in;
   logic [lph_pkg::SLOT_W-1:0]    res_slot_ff, res_slot_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [lph_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [lph_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                          rsp_free;

   logic                          req_acc;
   logic                          mod_start;
   logic                          mod_done;
   logic [lph_pkg::SLOT_W-1:0]    mod_rem;

   lph_pkg::ram_wr_type           wr_w;
   logic [lph_pkg::SLOT_W-1:0]    rd_addr_w;
   lph_pkg::row_type              rd_row;
   logic                          row_hit;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      table_size_in = table_size_ff;
      if (csr_wr && csr_paddr[2] == lph_pkg::REG_TABLE_SIZE) begin
         table_size_in = csr_pwdata[lph_pkg::SIZE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == lph_pkg::REG_TABLE_SIZE) begin
         csr_prdata = lph_pkg::CSR_DATA_W'(table_size_ff);
      end
   end

   // sizes above the store depth saturate to the depth
   assign cap_w = (table_size_ff > lph_pkg::SIZE_W'(lph_pkg::TABLE_DEPTH))
                  ? lph_pkg::SIZE_W'(lph_pkg::TABLE_DEPTH) : table_size_ff;

   // ---------------------------------------------------------------- request side
   assign req.ready = (state_ff == ST_IDLE);
   assign req_acc   = req.valid & req.ready;
   assign mod_start = req_acc & (req.cmd == lph_pkg::CMD_LOOKUP) & (cap_w != '0);

   // slot store write port: clearing pass or load word
   // the used flag stands for "key or sentinel nonzero", which is all a lookup needs
   always_comb begin
      wr_w = '0;
      if (state_ff == ST_CLEAR) begin
         wr_w.en   = 1'b1;
         wr_w.addr = clr_ff;
      end else begin
         wr_w.en         = req_acc & (req.cmd == lph_pkg::CMD_LOAD);
         wr_w.addr       = req.slot_index;
         wr_w.data.used  = (|req.entry_key) | (|req.entry_sentinel);
         wr_w.data.key   = req.entry_key;
         wr_w.data.value = req.entry_value;
      end
   end

   // ---------------------------------------------------------------- probe walk
   // the row of slot_ff is on the read port while in probe; the next slot is
   // fetched in the same cycle
   assign slot_inc  = {1'b0, slot_ff} + 1'b1;
   assign slot_next = (slot_inc == cap_ff) ? '0 : slot_inc[lph_pkg::SLOT_W-1:0];
   assign row_hit   = rd_row.used & (rd_row.key == key_ff);

   always_comb begin
      unique case (state_ff)
         ST_MOD:   rd_addr_w = mod_rem;
         ST_PROBE: rd_addr_w = slot_next;
         default:  rd_addr_w = '0;
      endcase
   end

   assign rsp_free = ~rsp_valid_ff | rsp.ready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cap_in       = cap_ff;
      key_in       = key_ff;
      slot_in      = slot_ff;
      left_in      = left_ff;
      res_found_in = res_found_ff;
      res_value_in = res_value_ff;
      res_slot_in  = res_slot_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      rsp_slot_in  = rsp_slot_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == lph_pkg::SLOT_W'(lph_pkg::TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc && req.cmd == lph_pkg::CMD_LOOKUP) begin
               cap_in       = cap_w;
               key_in       = req.entry_key;
               left_in      = cap_w;
               res_found_in = 1'b0;
               res_value_in = '0;
               res_slot_in  = '0;
               // empty table: straight to a miss
               state_in     = (cap_w == '0) ? ST_DONE : ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               slot_in  = mod_rem;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (row_hit) begin
               res_found_in = 1'b1;
               res_value_in = rd_row.value;
               res_slot_in  = slot_ff;
               state_in     = ST_DONE;
            end else if (!rd_row.used || left_ff == lph_pkg::SIZE_W'(1)) begin
               // empty slot or every slot probed: miss
               state_in = ST_DONE;
            end else begin
               slot_in = slot_next;
               left_in = left_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_value_in = res_value_ff;
               rsp_slot_in  = res_slot_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         table_size_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         table_size_ff <= table_size_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff       <= cap_in;
      key_ff       <= key_in;
      slot_ff      <= slot_in;
      left_ff      <= left_in;
      res_found_ff <= res_found_in;
      res_value_ff <= res_value_in;
      res_slot_ff  <= res_slot_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_slot_ff  <= rsp_slot_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.found        = rsp_found_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.hit_slot     = rsp_slot_ff;

   // ---------------------------------------------------------------- units
   lph_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req.entry_key),
      .divisor   (cap_w),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   lph_slot_ram u_ram (
      .clock   (clock),
      .wr      (wr_w),
      .rd_addr (rd_addr_w),
      .rd_data (rd_row)
   );

   // ---------------------------------------------------------------- checks
   a_probe_budget: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (left_ff != '0))
      else $error("probe walk with no probes left");

   a_probe_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> ({1'b0, slot_ff} < cap_ff))
      else $error("probe slot outside table");

   a_mod_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_MOD))
      else $error("start slot ready outside modulo state");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp.ready) |=> (state_ff == ST_DONE))
      else $error("result dropped while output register busy");

endmodule

>>> verif/linear_probe_hash_lookup_top_tb.sv
// testbench for linear_probe_hash_lookup_top: directed and random load and lookup words
// against an in-bench hash table predictor, random idling on both channels
// depends on lph_pkg, lph_req_if, lph_rsp_if and the block itself
`timescale 1ns / 100ps

module linear_probe_hash_lookup_top_tb;

   localparam int CLOCK_PERIOD    = 8;
   localparam int RUN_LIMIT       = 5_000_000;   // cycles before the run is called hung
   localparam int SETTLE_CYCLES   = 24;          // slack after the last word, lets a trailing load finish
   localparam int PHASES          = 15;
   localparam int WORDS_PER_PHASE = 62;
   localparam int REPORT_LIMIT    = 10;

   // register map: table_size at byte 0, byte 4 is unmapped
   localparam logic [lph_pkg::CSR_ADDR_W-1:0] TABLE_SIZE_ADDR = {lph_pkg::REG_TABLE_SIZE, 2'b00};
   localparam logic [lph_pkg::CSR_ADDR_W-1:0] SPARE_ADDR      = {1'b1, 2'b00};
   localparam logic                           CSR_WRITE       = 1'b1;
   localparam logic                           CSR_READ        = 1'b0;

   typedef struct {
      logic                         cmd;
      logic [lph_pkg::SLOT_W-1:0]   slot;
      logic [lph_pkg::KEY_W-1:0]    key;
      logic [lph_pkg::KEY_W-1:0]    sentinel;
      logic [lph_pkg::VALUE_W-1:0]  value;
   } hash_word_type;

   typedef struct packed {
      logic                         found;
      logic [lph_pkg::VALUE_W-1:0]  value;
      logic [lph_pkg::SLOT_W-1:0]   slot;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [lph_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [lph_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [lph_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   lph_req_if req_bus ();
   lph_rsp_if rsp_bus ();

   linear_probe_hash_lookup_top dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // predictor state: slot stores and the table size as the block should hold them
   bit [lph_pkg::KEY_W-1:0]    model_keys      [lph_pkg::TABLE_DEPTH];
   bit [lph_pkg::KEY_W-1:0]    model_sentinels [lph_pkg::TABLE_DEPTH];
   bit [lph_pkg::VALUE_W-1:0]  model_values    [lph_pkg::TABLE_DEPTH];
   logic [lph_pkg::SIZE_W-1:0] table_size_model = '0;

   // stimulus-side picture of the slots, used only to place keys like a real insert
   bit [lph_pkg::KEY_W-1:0]    layout_key  [lph_pkg::TABLE_DEPTH];
   bit [lph_pkg::KEY_W-1:0]    layout_sent [lph_pkg::TABLE_DEPTH];
   logic [lph_pkg::KEY_W-1:0]  live_keys [$];

   hash_word_type     pending_words [$];
   hash_word_type     word_on_bus;
   lookup_result_type awaited_results [$];

   int words_queued   = 0;
   int words_accepted = 0;
   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;

   task automatic note_mismatch(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // walk the table from key mod size, as a lookup word does
   function automatic lookup_result_type probe_table(input logic [lph_pkg::KEY_W-1:0] key);
      lookup_result_type res;
      int unsigned cap;
      int unsigned slot;
      res = '0;
      cap = (table_size_model > lph_pkg::TABLE_DEPTH) ? lph_pkg::TABLE_DEPTH
                                                      : table_size_model;
      if (cap != 0) begin
         slot = int'(key % lph_pkg::KEY_W'(cap));
         for (int unsigned n = 0; n < cap; n++) begin
            // empty slot ends the search before any key compare
            if (model_keys[slot] == '0 && model_sentinels[slot] == '0)
               break;
            if (model_keys[slot] == key) begin
               res.found = 1'b1;
               res.value = model_values[slot];
               res.slot  = slot[lph_pkg::SLOT_W-1:0];
               break;
            end
            slot = (slot + 1 == cap) ? 0 : slot + 1;
         end
      end
      return res;
   endfunction

   // called at the edge where a word is taken
   task automatic apply_word(input hash_word_type w);
      words_accepted++;
      if (w.cmd == lph_pkg::CMD_LOAD) begin
         model_keys[w.slot]      = w.key;
         model_sentinels[w.slot] = w.sentinel;
         model_values[w.slot]    = w.value;
      end else begin
         awaited_results.insert(awaited_results.size(), probe_table(w.key));
      end
   endtask

   // request driver: a word stays on the bus until taken, a new one may follow at once
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            apply_word(word_on_bus);
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               word_on_bus = pending_words.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.cmd            <= word_on_bus.cmd;
               req_bus.slot_index     <= word_on_bus.slot;
               req_bus.entry_key      <= word_on_bus.key;
               req_bus.entry_sentinel <= word_on_bus.sentinel;
               req_bus.entry_value    <= word_on_bus.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: random backpressure, each taken word checked against the oldest prediction
   always @(posedge clock) begin : result_check
      lookup_result_type want;
      lookup_result_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.found = rsp_bus.found;
            got.value = rsp_bus.result_value;
            got.slot  = rsp_bus.hit_slot;
            if (awaited_results.size() == 0) begin
               note_mismatch($sformatf("unexpected result found=%b value=%h slot=%0d",
                                       got.found, got.value, got.slot));
            end else begin
               want = awaited_results.pop_front();
               if (got.found !== want.found || got.value !== want.value ||
                   got.slot !== want.slot)
                  note_mismatch($sformatf(
                     "found %b/%b value %h/%h slot %0d/%0d (expected/actual)",
                     want.found, got.found, want.value, got.value, want.slot, got.slot));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // hang guard
   initial begin
      #(CLOCK_PERIOD * RUN_LIMIT);
      $display("status: fail");
      $finish;
   end

   task automatic push_load(input logic [lph_pkg::SLOT_W-1:0] slot,
                            input logic [lph_pkg::KEY_W-1:0] key,
                            input logic [lph_pkg::KEY_W-1:0] sent,
                            input logic [lph_pkg::VALUE_W-1:0] value);
      hash_word_type w;
      w.cmd = lph_pkg::CMD_LOAD;
      w.slot = slot;
      w.key = key;
      w.sentinel = sent;
      w.value = value;
      layout_key[slot]  = key;
      layout_sent[slot] = sent;
      pending_words.insert(pending_words.size(), w);
      words_queued++;
   endtask

   task automatic push_lookup(input logic [lph_pkg::KEY_W-1:0] key);
      hash_word_type w;
      w.cmd = lph_pkg::CMD_LOOKUP;
      w.slot = lph_pkg::SLOT_W'($urandom);   // don't care on a lookup, keep it moving
      w.key = key;
      w.sentinel = {$urandom, $urandom};
      w.value = $urandom;
      pending_words.insert(pending_words.size(), w);
      words_queued++;
   endtask

   // place a key the way a host would: first empty or matching slot from key mod size,
   // a random victim when the used part of the table is full
   task automatic insert_key(input logic [lph_pkg::KEY_W-1:0] key,
                             input logic [lph_pkg::KEY_W-1:0] sent,
                             input logic [lph_pkg::VALUE_W-1:0] value, input int cap);
      int slot;
      int target;
      target = -1;
      slot = int'(key % lph_pkg::KEY_W'(cap));
      for (int n = 0; n < cap && target < 0; n++) begin
         if ((layout_key[slot] == '0 && layout_sent[slot] == '0) || layout_key[slot] == key)
            target = slot;
         slot = (slot + 1 == cap) ? 0 : slot + 1;
      end
      if (target < 0)
         target = $urandom_range(cap - 1);
      push_load(target[lph_pkg::SLOT_W-1:0], key, sent, value);
   endtask

   function automatic logic [lph_pkg::KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(99);
      if (r < 50)
         return {$urandom, $urandom};
      else if (r < 88)
         return lph_pkg::KEY_W'($urandom_range(4095));   // small keys pile up on the same slots
      else if (r < 94)
         return '0;
      else
         return '1;
   endfunction

   // wait until every word is taken and answered, then let a trailing load finish
   task automatic settle();
      while (words_accepted != words_queued || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb transfer, setup then access phase; a read of table_size is checked against the prediction
   task automatic csr_access(input logic write, input logic [lph_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [lph_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (write) begin
         if (addr == TABLE_SIZE_ADDR)
            table_size_model = data[lph_pkg::SIZE_W-1:0];
      end else if (addr == TABLE_SIZE_ADDR &&
                   csr_prdata !== lph_pkg::CSR_DATA_W'(table_size_model)) begin
         note_mismatch($sformatf("table_size readback expected %0d got %0d",
                                 table_size_model, csr_prdata));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_table_size(input int size);
      settle();
      csr_access(CSR_WRITE, TABLE_SIZE_ADDR, lph_pkg::CSR_DATA_W'(size));
      csr_access(CSR_READ, TABLE_SIZE_ADDR, '0);
   endtask

   initial begin : stimulus
      int size;
      int cap;
      int pick;
      logic [lph_pkg::KEY_W-1:0] key;
      logic [lph_pkg::KEY_W-1:0] sent;

      // every input known before the first edge
      req_bus.valid          = 1'b0;
      req_bus.cmd            = lph_pkg::CMD_LOAD;
      req_bus.slot_index     = '0;
      req_bus.entry_key      = '0;
      req_bus.entry_sentinel = '0;
      req_bus.entry_value    = '0;
      rsp_bus.ready          = 1'b0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 24;
      recv_idle_pct = 52;

      // size zero after reset: every lookup misses, zero fields
      push_lookup('0);
      push_lookup('1);

      // write to the unmapped address must leave table_size alone
      settle();
      csr_access(CSR_WRITE, SPARE_ADDR, 32'h5);
      csr_access(CSR_READ, TABLE_SIZE_ADDR, '0);

      // size beyond depth saturates; top slot hit, and a chain wrapping from 1023 to 0
      set_table_size(2047);
      push_load(10'd1023, '1, '1, '1);
      push_load(10'd0, 64'd2047, '0, 32'h1234_5678);
      push_lookup('1);
      push_lookup(64'd2047);
      push_lookup(64'd1023);

      set_table_size(lph_pkg::TABLE_DEPTH);
      push_lookup('1);

      // three-slot table: zero key with sentinel is a live entry, full table miss,
      // emptied slot cuts the chain
      set_table_size(3);
      push_load(10'd0, '0, 64'd5, 32'hAAAA_0000);
      push_load(10'd1, 64'd4, '0, 32'h0000_BBBB);
      push_load(10'd2, 64'd7, 64'd1, 32'hCCCC_CCCC);
      push_lookup('0);
      push_lookup(64'd7);
      push_lookup(64'd5);
      push_load(10'd1, '0, '0, '0);
      push_lookup(64'd4);
      push_lookup('0);

      // one-slot table
      set_table_size(1);
      push_lookup(64'd9);
      push_lookup('0);

      // random part: mostly real inserts and lookups of live keys, plus chain breaks
      // and stray loads; each phase starts from an idle block with a new size
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < PHASES / 3) begin
            send_idle_pct = 24;
            recv_idle_pct = 52;
         end else if (phase < 2 * PHASES / 3) begin
            send_idle_pct = 52;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            0: size = 1;
            1: size = lph_pkg::TABLE_DEPTH;
            2: size = $urandom_range(2047, lph_pkg::TABLE_DEPTH + 1);
            7: size = 2;
            default: size = $urandom_range(48, 3);
         endcase
         // pause the sender here until everything has come back
         set_table_size(size);
         cap = (size > lph_pkg::TABLE_DEPTH) ? lph_pkg::TABLE_DEPTH : size;
         live_keys.delete();

         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 30 || live_keys.size() == 0) begin
               key  = pick_key();
               sent = ($urandom_range(7) == 0) ? '0 : {$urandom, $urandom};
               if (key == '0 && sent == '0)
                  sent = 64'd1;
               insert_key(key, sent, $urandom, cap);
               live_keys.insert(live_keys.size(), key);
            end else if (pick < 60) begin
               push_lookup(live_keys[$urandom_range(live_keys.size() - 1)]);
            end else if (pick < 72) begin
               // same start slot as a live key, most likely absent: long probe walks
               key = live_keys[$urandom_range(live_keys.size() - 1)];
               push_lookup(key + lph_pkg::KEY_W'(cap) *
                                 lph_pkg::KEY_W'($urandom_range(3, 1)));
            end else if (pick < 80) begin
               push_lookup({$urandom, $urandom});
            end else if (pick < 88) begin
               push_load(lph_pkg::SLOT_W'($urandom_range(cap - 1)), '0, '0, $urandom);
            end else if (pick < 94) begin
               push_load(lph_pkg::SLOT_W'($urandom_range(lph_pkg::TABLE_DEPTH - 1)),
                         pick_key(), {$urandom, $urandom}, $urandom);
            end else begin
               push_lookup('0);
            end
         end
      end

      settle();
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
